@@ hdl/mtp_pkg.sv @@
// Shared types, constants and a decode function for the Modbus/TCP header parser.
package mtp_pkg;

    localparam int unsigned MbapHdrLen  = 7;
    localparam logic [15:0] DefaultPort = 16'd502;
    localparam logic [7:0]  FcMask      = 8'h7F;
    localparam logic [7:0]  FcExcBit    = 8'h80;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic REG_SERVICE_PORT = 1'b0;

    // Confidence codes.
    localparam logic [1:0] CONF_NONE  = 2'd0;
    localparam logic [1:0] CONF_MATCH = 2'd1;
    localparam logic [1:0] CONF_PORT  = 2'd2;

    // Detail kinds.
    localparam logic [1:0] DETAIL_NONE  = 2'd0;
    localparam logic [1:0] DETAIL_READ  = 2'd1;
    localparam logic [1:0] DETAIL_WRITE = 2'd2;

    // Header state as it stands after the current byte has been taken in.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] trans_id;
        logic [15:0] proto_id;
        logic [15:0] decl_len;
        logic [7:0]  unit_id;
        logic [7:0]  func_code;
        logic [31:0] data_head;
    } t_hdr;

    typedef struct packed {
        logic [15:0] qty_or_value;
        logic [15:0] reg_address;
        logic [1:0]  detail_kind;
        logic [7:0]  exception_code;
        logic        exc_code_present;
        logic        is_exception;
        logic        function_known;
        logic [7:0]  func_byte;
        logic [7:0]  unit_id;
        logic [15:0] txn_id;
        logic [1:0]  confidence;
    } t_result;

    // True when the low seven bits are one of the function codes 1-8, 15-17, 20-24 or 43.
    function automatic logic code_is_named(input logic [7:0] fc);
        logic [7:0] c;
        c = fc & FcMask;
        return ((c >= 8'd1)  && (c <= 8'd8))  ||
               ((c >= 8'd15) && (c <= 8'd17)) ||
               ((c >= 8'd20) && (c <= 8'd24)) ||
               (c == 8'd43);
    endfunction

endpackage

@@ hdl/mtp_capture.sv @@
// Byte position counter and MBAP header capture registers.
module mtp_capture (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_last,
    input  logic [7:0]       i_byte,
    output mtp_pkg::t_hdr    o_hdr
);

    logic [15:0] r_byte_count;
    logic [15:0] r_trans_id;
    logic [15:0] r_proto_id;
    logic [15:0] r_decl_len;
    logic [7:0]  r_unit_id;
    logic [7:0]  r_func_code;
    logic [31:0] r_data_head;

    mtp_pkg::t_hdr n_hdr;

    // Merge the incoming byte into the header at its position.
    always_comb begin
        n_hdr.byte_count = (r_byte_count == 16'hFFFF) ? r_byte_count : r_byte_count + 16'd1;
        n_hdr.trans_id   = r_trans_id;
        n_hdr.proto_id   = r_proto_id;
        n_hdr.decl_len   = r_decl_len;
        n_hdr.unit_id    = r_unit_id;
        n_hdr.func_code  = r_func_code;
        n_hdr.data_head  = r_data_head;
        unique case (r_byte_count)
            16'd0:   n_hdr.trans_id[15:8]  = i_byte;
            16'd1:   n_hdr.trans_id[7:0]   = i_byte;
            16'd2:   n_hdr.proto_id[15:8]  = i_byte;
            16'd3:   n_hdr.proto_id[7:0]   = i_byte;
            16'd4:   n_hdr.decl_len[15:8]  = i_byte;
            16'd5:   n_hdr.decl_len[7:0]   = i_byte;
            16'd6:   n_hdr.unit_id         = i_byte;
            16'd7:   n_hdr.func_code       = i_byte;
            16'd8:   n_hdr.data_head[31:24] = i_byte;
            16'd9:   n_hdr.data_head[23:16] = i_byte;
            16'd10:  n_hdr.data_head[15:8]  = i_byte;
            16'd11:  n_hdr.data_head[7:0]   = i_byte;
            default: ;
        endcase
    end

    assign o_hdr = n_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_byte_count <= '0;
            r_trans_id   <= '0;
            r_proto_id   <= '0;
            r_decl_len   <= '0;
            r_unit_id    <= '0;
            r_func_code  <= '0;
            r_data_head  <= '0;
        end else if (i_accept) begin
            r_byte_count <= n_hdr.byte_count;
            r_trans_id   <= n_hdr.trans_id;
            r_proto_id   <= n_hdr.proto_id;
            r_decl_len   <= n_hdr.decl_len;
            r_unit_id    <= n_hdr.unit_id;
            r_func_code  <= n_hdr.func_code;
            r_data_head  <= n_hdr.data_head;
        end
    end

endmodule

@@ hdl/mtp_classify.sv @@
// Packet acceptance check and function code decode for one finished payload.
module mtp_classify (
    input  mtp_pkg::t_hdr    i_hdr,
    input  logic [15:0]      i_dest_port,
    input  logic             i_is_tcp,
    input  logic [15:0]      i_service_port,
    output mtp_pkg::t_result o_result
);

    logic        valid_pkt;
    logic        has_data1;
    logic        has_data4;
    logic        exc;
    logic [16:0] frame_end;

    always_comb begin
        frame_end = {1'b0, i_hdr.decl_len} + 17'(mtp_pkg::MbapHdrLen - 1);
        valid_pkt = i_is_tcp &&
                    (i_hdr.byte_count >= 16'(mtp_pkg::MbapHdrLen + 1)) &&
                    (i_hdr.proto_id == 16'd0) &&
                    (i_hdr.decl_len >= 16'd2) &&
                    (frame_end <= {1'b0, i_hdr.byte_count});
        // Data length is min(decl_len - 2, byte_count - 8); test its two thresholds.
        has_data1 = (i_hdr.decl_len >= 16'd3) && (i_hdr.byte_count >= 16'd9);
        has_data4 = (i_hdr.decl_len >= 16'd6) && (i_hdr.byte_count >= 16'd12);
        exc       = (i_hdr.func_code & mtp_pkg::FcExcBit) != 8'd0;

        o_result = '0;
        if (valid_pkt) begin
            o_result.confidence     = (i_dest_port == i_service_port) ?
                                      mtp_pkg::CONF_PORT : mtp_pkg::CONF_MATCH;
            o_result.txn_id         = i_hdr.trans_id;
            o_result.unit_id        = i_hdr.unit_id;
            o_result.func_byte      = i_hdr.func_code;
            o_result.function_known = mtp_pkg::code_is_named(i_hdr.func_code);
            o_result.is_exception   = exc;
            if (exc) begin
                if (has_data1) begin
                    o_result.exc_code_present = 1'b1;
                    o_result.exception_code   = i_hdr.data_head[31:24];
                end
            end else if (has_data4) begin
                if ((i_hdr.func_code >= 8'd1) && (i_hdr.func_code <= 8'd4)) begin
                    o_result.detail_kind = mtp_pkg::DETAIL_READ;
                end else if ((i_hdr.func_code == 8'd5) || (i_hdr.func_code == 8'd6)) begin
                    o_result.detail_kind = mtp_pkg::DETAIL_WRITE;
                end
                if (o_result.detail_kind != mtp_pkg::DETAIL_NONE) begin
                    o_result.reg_address  = i_hdr.data_head[31:16];
                    o_result.qty_or_value = i_hdr.data_head[15:0];
                end
            end
        end
    end

endmodule

@@ hdl/modbus_tcp_header_parser.sv @@
// Top level of the Modbus/TCP MBAP header parser: handshakes, register port, result register.
//
// The parser takes a TCP payload one byte per transaction on the slave stream and,
// on the transaction marked tlast, gives one result transaction on the master stream.
// Bytes are taken at one per clock cycle while tready is high, with no gaps between packets;
// the result of a packet is in the output register in the cycle after its last byte is
// accepted. The only thing that holds the input back is the single output register: while
// it holds a result that the downstream side does not take, tready is low. A packet counts as
// Modbus/TCP when it is TCP, at least eight bytes long, has protocol id zero and a
// declared length of at least two that fits in the payload; confidence is then high when
// the destination port equals the service_port register (byte address 0, reset 502) and
// medium otherwise. A rejected packet gives a result with every field zero. Byte counts
// saturate at 65535; bytes past the first four data bytes are only counted. The
// service_port register should be written only while no packet is in flight.
module modbus_tcp_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: one payload byte per transaction.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] data_byte, [23:8] dest_port
    input  logic        i_s_axis_tlast,   // last_byte
    input  logic        i_s_axis_tuser,   // [0] is_tcp
    // Master stream: one result per packet.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] confidence, [17:2] txn_id, [25:18] unit_id, [33:26] func_byte,
    // [34] function_known, [35] is_exception, [36] exc_code_present,
    // [44:37] exception_code, [60:45] reg_address, [76:61] qty_or_value, [79:77] zero
    output logic [79:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [1:0] detail_kind
    // Register port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic              s_accept;
    logic              last_accept;
    logic [15:0]       r_service_port;
    logic              r_out_valid;
    mtp_pkg::t_result  r_out;
    mtp_pkg::t_hdr     hdr;
    mtp_pkg::t_result  result;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign last_accept     = s_accept && i_s_axis_tlast;

    // Register port: zero wait states, one register.
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == mtp_pkg::REG_SERVICE_PORT) ? {16'd0, r_service_port} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_port <= mtp_pkg::DefaultPort;
        end else if (i_psel && i_penable && i_pwrite && o_pready &&
                     (i_paddr == mtp_pkg::REG_SERVICE_PORT)) begin
            r_service_port <= i_pwdata[15:0];
        end
    end

    mtp_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_last   (i_s_axis_tlast),
        .i_byte   (i_s_axis_tdata[7:0]),
        .o_hdr    (hdr)
    );

    mtp_classify u_classify (
        .i_hdr          (hdr),
        .i_dest_port    (i_s_axis_tdata[23:8]),
        .i_is_tcp       (i_s_axis_tuser),
        .i_service_port (r_service_port),
        .o_result       (result)
    );

    // Result register: loaded on the last byte, freed when the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (last_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_accept) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.detail_kind;
    assign o_m_axis_tdata  = {3'd0,
                              r_out.qty_or_value,
                              r_out.reg_address,
                              r_out.exception_code,
                              r_out.exc_code_present,
                              r_out.is_exception,
                              r_out.function_known,
                              r_out.func_byte,
                              r_out.unit_id,
                              r_out.txn_id,
                              r_out.confidence};

endmodule

@@ hdl/mtp_checker.sv @@
// Port-level checks for the Modbus/TCP header parser, bound to the top level.
module mtp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // No result is pending right after a reset cycle.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // An empty result slot never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // A rejected packet reports all fields as zero.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[1:0] == mtp_pkg::CONF_NONE) |->
            (o_m_axis_tdata[79:2] == 78'd0) && (o_m_axis_tuser == mtp_pkg::DETAIL_NONE))
        else $error("rejected packet with nonzero fields");

    // Request details come only from accepted non-exception packets.
    a_detail_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != mtp_pkg::DETAIL_NONE) |->
            (o_m_axis_tdata[1:0] != mtp_pkg::CONF_NONE) && !o_m_axis_tdata[35] &&
            !o_m_axis_tdata[36])
        else $error("detail on exception or rejected packet");

endmodule

bind modbus_tcp_header_parser mtp_checker u_mtp_checker (.*);
